FILE: hdl/length_prefixed_frame_parser_unit_macros.svh
// Assertion macros shared by the frame parser modules.
`ifndef LENGTH_PREFIXED_FRAME_PARSER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define LPFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define LPFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/lpfp_pkg.sv
package lpfp_pkg;

    localparam int MAX_PAYLOAD  = 48;
    localparam int BUF_DEPTH    = 60;
    localparam int ADDR_W       = $clog2(BUF_DEPTH);
    localparam int MEM_SIZE     = 2 ** ADDR_W;
    localparam int CNT_W        = $clog2(BUF_DEPTH + 1);
    localparam int LEN_W        = 6;
    localparam int TOT_W        = CNT_W + 1;

    typedef enum logic [2:0] {
        CFG_HDR_LEN   = 3'd0,
        CFG_HDR_BYTES = 3'd1,
        CFG_LEN_SIZE  = 3'd2,
        CFG_ORDER     = 3'd3,
        CFG_CSUM_SIZE = 3'd4,
        CFG_CSUM_CHK  = 3'd5,
        CFG_CSUM_SEED = 3'd6,
        CFG_MAX_LEN   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_HDR_ERR  = 2'd1,
        ST_LEN_ERR  = 2'd2,
        ST_CSUM_ERR = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_HDR = 2'd0,
        RD_LEN = 2'd1,
        RD_SUM = 2'd2,
        RD_TRL = 2'd3
    } t_rd_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HDR_CHK,
        S_HDR_RD,
        S_HDR_CMP,
        S_LEN_CHK,
        S_LEN_RD,
        S_LEN_ACC,
        S_LIM_CHK,
        S_SUM_RD,
        S_SUM_ACC,
        S_TRL_RD,
        S_TRL_CMP,
        S_EMIT,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    idx_clr;
        logic    idx_inc;
        logic    len_clr;
        logic    len_acc;
        logic    sum_init;
        logic    sum_acc;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    res_load;
        t_status res_code;
        logic    emit;
        logic    flush;
    } t_cmd;

    typedef struct packed {
        logic cnt_lt_hl;
        logic hl_zero;
        logic hdr_mism;
        logic idx_last_hl;
        logic cnt_lt_hl_ls;
        logic idx_last_ls;
        logic len_gt_lim;
        logic cnt_lt_total;
        logic chk_on;
        logic len_zero;
        logic idx_last_len;
        logic sum_bad;
        logic emit_block;
        logic pend_valid;
    } t_sts;

endpackage

FILE: hdl/lpfp_ctrl.sv
`include "length_prefixed_frame_parser_unit_macros.svh"

module lpfp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lpfp_pkg::t_sts i_sts,
    output lpfp_pkg::t_cmd o_cmd
);

    lpfp_pkg::t_state r_state;
    lpfp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpfp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lpfp_pkg::S_IDLE: begin
                if (i_in_valid) n_state = lpfp_pkg::S_HDR_CHK;
            end
            lpfp_pkg::S_HDR_CHK: begin
                if (i_sts.cnt_lt_hl)    n_state = lpfp_pkg::S_FLUSH;
                else if (i_sts.hl_zero) n_state = lpfp_pkg::S_LEN_CHK;
                else                    n_state = lpfp_pkg::S_HDR_RD;
            end
            lpfp_pkg::S_HDR_RD: n_state = lpfp_pkg::S_HDR_CMP;
            lpfp_pkg::S_HDR_CMP: begin
                if (i_sts.hdr_mism)         n_state = lpfp_pkg::S_EMIT;
                else if (i_sts.idx_last_hl) n_state = lpfp_pkg::S_LEN_CHK;
                else                        n_state = lpfp_pkg::S_HDR_RD;
            end
            lpfp_pkg::S_LEN_CHK: begin
                if (i_sts.cnt_lt_hl_ls) n_state = lpfp_pkg::S_FLUSH;
                else                    n_state = lpfp_pkg::S_LEN_RD;
            end
            lpfp_pkg::S_LEN_RD: n_state = lpfp_pkg::S_LEN_ACC;
            lpfp_pkg::S_LEN_ACC: begin
                if (i_sts.idx_last_ls) n_state = lpfp_pkg::S_LIM_CHK;
                else                   n_state = lpfp_pkg::S_LEN_RD;
            end
            lpfp_pkg::S_LIM_CHK: begin
                if (i_sts.len_gt_lim)        n_state = lpfp_pkg::S_EMIT;
                else if (i_sts.cnt_lt_total) n_state = lpfp_pkg::S_FLUSH;
                else if (!i_sts.chk_on)      n_state = lpfp_pkg::S_EMIT;
                else if (i_sts.len_zero)     n_state = lpfp_pkg::S_TRL_RD;
                else                         n_state = lpfp_pkg::S_SUM_RD;
            end
            lpfp_pkg::S_SUM_RD: n_state = lpfp_pkg::S_SUM_ACC;
            lpfp_pkg::S_SUM_ACC: begin
                if (i_sts.idx_last_len) n_state = lpfp_pkg::S_TRL_RD;
                else                    n_state = lpfp_pkg::S_SUM_RD;
            end
            lpfp_pkg::S_TRL_RD:  n_state = lpfp_pkg::S_TRL_CMP;
            lpfp_pkg::S_TRL_CMP: n_state = lpfp_pkg::S_EMIT;
            lpfp_pkg::S_EMIT: begin
                if (!i_sts.emit_block) n_state = lpfp_pkg::S_HDR_CHK;
            end
            lpfp_pkg::S_FLUSH: begin
                if (!i_sts.emit_block) n_state = lpfp_pkg::S_IDLE;
            end
            default: n_state = lpfp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_sel   = lpfp_pkg::RD_HDR;
        o_cmd.res_code = lpfp_pkg::ST_OK;
        o_in_ready     = 1'b0;
        case (r_state)
            lpfp_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            lpfp_pkg::S_HDR_CHK: o_cmd.idx_clr = 1'b1;
            lpfp_pkg::S_HDR_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = lpfp_pkg::RD_HDR;
            end
            lpfp_pkg::S_HDR_CMP: begin
                o_cmd.idx_inc  = 1'b1;
                o_cmd.res_load = i_sts.hdr_mism;
                o_cmd.res_code = lpfp_pkg::ST_HDR_ERR;
            end
            lpfp_pkg::S_LEN_CHK: begin
                o_cmd.idx_clr = 1'b1;
                o_cmd.len_clr = 1'b1;
            end
            lpfp_pkg::S_LEN_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = lpfp_pkg::RD_LEN;
            end
            lpfp_pkg::S_LEN_ACC: begin
                o_cmd.len_acc = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            lpfp_pkg::S_LIM_CHK: begin
                o_cmd.idx_clr  = 1'b1;
                o_cmd.sum_init = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_code = i_sts.len_gt_lim ? lpfp_pkg::ST_LEN_ERR : lpfp_pkg::ST_OK;
            end
            lpfp_pkg::S_SUM_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = lpfp_pkg::RD_SUM;
            end
            lpfp_pkg::S_SUM_ACC: begin
                o_cmd.sum_acc = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            lpfp_pkg::S_TRL_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = lpfp_pkg::RD_TRL;
            end
            lpfp_pkg::S_TRL_CMP: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_code = i_sts.sum_bad ? lpfp_pkg::ST_CSUM_ERR : lpfp_pkg::ST_OK;
            end
            lpfp_pkg::S_EMIT:  o_cmd.emit  = !i_sts.emit_block;
            lpfp_pkg::S_FLUSH: o_cmd.flush = !i_sts.emit_block;
            default: o_cmd = '0;
        endcase
    end

    `LPFP_ASSERT_IMPL(a_idle_no_pending, i_clk, i_rst_n, r_state == lpfp_pkg::S_IDLE, !i_sts.pend_valid)
    `LPFP_ASSERT_NEXT(a_emit_rescans, i_clk, i_rst_n, o_cmd.emit, r_state == lpfp_pkg::S_HDR_CHK)

endmodule

FILE: hdl/lpfp_dpath.sv
`include "length_prefixed_frame_parser_unit_macros.svh"

module lpfp_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [7:0]                     i_in_byte,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_status,
    output logic [lpfp_pkg::LEN_W-1:0]     o_frame_length,
    output logic                           o_last,
    input  lpfp_pkg::t_cmd                 i_cmd,
    output lpfp_pkg::t_sts                 o_sts
);

    localparam int AW = lpfp_pkg::ADDR_W;
    localparam int CW = lpfp_pkg::CNT_W;
    localparam int TW = lpfp_pkg::TOT_W;
    localparam int LW = lpfp_pkg::LEN_W;

    // Configuration registers.
    logic [2:0]  r_hdr_len;
    logic [31:0] r_hdr_bytes;
    logic [1:0]  r_len_size;
    logic [1:0]  r_order;
    logic [1:0]  r_csum_size;
    logic        r_csum_chk;
    logic [7:0]  r_seed;
    logic [5:0]  r_max_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_len   <= '0;
            r_hdr_bytes <= '0;
            r_len_size  <= 2'd1;
            r_order     <= '0;
            r_csum_size <= '0;
            r_csum_chk  <= 1'b0;
            r_seed      <= '0;
            r_max_len   <= 6'(lpfp_pkg::MAX_PAYLOAD);
        end else if (i_cfg_we) begin
            case (lpfp_pkg::t_cfg_idx'(i_cfg_index))
                lpfp_pkg::CFG_HDR_LEN:   r_hdr_len   <= i_cfg_data[2:0];
                lpfp_pkg::CFG_HDR_BYTES: r_hdr_bytes <= i_cfg_data;
                lpfp_pkg::CFG_LEN_SIZE:  r_len_size  <= i_cfg_data[1:0];
                lpfp_pkg::CFG_ORDER:     r_order     <= i_cfg_data[1:0];
                lpfp_pkg::CFG_CSUM_SIZE: r_csum_size <= i_cfg_data[1:0];
                lpfp_pkg::CFG_CSUM_CHK:  r_csum_chk  <= i_cfg_data[0];
                lpfp_pkg::CFG_CSUM_SEED: r_seed      <= i_cfg_data[7:0];
                lpfp_pkg::CFG_MAX_LEN:   r_max_len   <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic [2:0] hl;
    logic [2:0] ls;
    logic [2:0] cs;
    logic [5:0] limit;

    assign hl    = (r_hdr_len > 3'd4) ? 3'd4 : r_hdr_len;
    assign limit = (r_max_len > 6'(lpfp_pkg::MAX_PAYLOAD)) ? 6'(lpfp_pkg::MAX_PAYLOAD)
                                                           : r_max_len;
    always_comb begin
        case (r_len_size)
            2'd0:    ls = 3'd1;
            2'd1:    ls = 3'd2;
            default: ls = 3'd4;
        endcase
        case (r_csum_size)
            2'd0:    cs = 3'd0;
            2'd1:    cs = 3'd1;
            2'd2:    cs = 3'd2;
            default: cs = 3'd4;
        endcase
    end

    // Circular byte buffer: oldest byte at r_head, r_cnt bytes held.
    logic [7:0]    mem [lpfp_pkg::MEM_SIZE];
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_cnt;
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_idx;
    logic [31:0]   r_plen;
    logic [7:0]    r_sum;
    logic [1:0]    r_res_status;
    logic [LW-1:0] r_res_len;
    logic          r_pend_valid;
    logic [1:0]    r_pend_status;
    logic [LW-1:0] r_pend_len;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [LW-1:0] r_out_len;
    logic          r_out_last;

    logic          buf_full;
    logic [AW-1:0] wr_addr;
    logic [TW-1:0] total;
    logic [TW-1:0] rd_off;
    logic [AW-1:0] rd_addr;
    logic [TW-1:0] drop_n;
    logic [2:0]    trl_off;
    logic          out_busy;

    assign buf_full = (r_cnt == CW'(lpfp_pkg::BUF_DEPTH));
    assign wr_addr  = AW'({1'b0, r_head} + TW'(r_cnt));
    assign total    = TW'(hl) + TW'(ls) + TW'(r_plen[LW-1:0]) + TW'(cs);
    assign trl_off  = r_order[1] ? (cs - 3'd1) : 3'd0;

    always_comb begin
        case (i_cmd.rd_sel)
            lpfp_pkg::RD_HDR: rd_off = TW'(r_idx);
            lpfp_pkg::RD_LEN: rd_off = TW'(hl) + TW'(r_idx);
            lpfp_pkg::RD_SUM: rd_off = TW'(hl) + TW'(ls) + TW'(r_idx);
            lpfp_pkg::RD_TRL: rd_off = TW'(hl) + TW'(ls) + TW'(r_plen[LW-1:0]) + TW'(trl_off);
            default:          rd_off = '0;
        endcase
    end
    assign rd_addr = AW'(TW'(r_head) + rd_off);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) mem[wr_addr] <= i_in_byte;
        if (i_cmd.rd_en)  r_rd_data    <= mem[rd_addr];
    end

    // An error drops one byte; a good frame is consumed whole.
    assign drop_n = (r_res_status == lpfp_pkg::ST_OK) ? total : TW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.accept) begin
            if (buf_full) r_head <= r_head + AW'(1);
            else          r_cnt  <= r_cnt + CW'(1);
        end else if (i_cmd.emit) begin
            r_head <= AW'(TW'(r_head) + drop_n);
            r_cnt  <= CW'(TW'(r_cnt) - drop_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr)      r_idx <= '0;
        else if (i_cmd.idx_inc) r_idx <= r_idx + CW'(1);
        if (i_cmd.len_clr) begin
            r_plen <= '0;
        end else if (i_cmd.len_acc) begin
            if (r_order[0]) r_plen <= {r_plen[23:0], r_rd_data};
            else            r_plen <= r_plen | ({24'd0, r_rd_data} << {r_idx[1:0], 3'b000});
        end
        if (i_cmd.sum_init)     r_sum <= r_seed;
        else if (i_cmd.sum_acc) r_sum <= r_sum + r_rd_data;
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_code;
            r_res_len    <= (i_cmd.res_code == lpfp_pkg::ST_OK) ? r_plen[LW-1:0] : '0;
        end
    end

    // The newest result waits in a pending slot until the next one or the end of
    // the scan tells whether it is the last for this word.
    assign out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if ((i_cmd.emit || i_cmd.flush) && r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_pend_status;
                r_out_len    <= r_pend_len;
                r_out_last   <= i_cmd.flush;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_pend_valid  <= 1'b1;
                r_pend_status <= r_res_status;
                r_pend_len    <= r_res_len;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_frame_length = r_out_len;
    assign o_last         = r_out_last;

    always_comb begin
        o_sts.cnt_lt_hl    = r_cnt < CW'(hl);
        o_sts.hl_zero      = (hl == 3'd0);
        o_sts.hdr_mism     = r_rd_data != r_hdr_bytes[{r_idx[1:0], 3'b000} +: 8];
        o_sts.idx_last_hl  = (r_idx + CW'(1)) == CW'(hl);
        o_sts.cnt_lt_hl_ls = TW'(r_cnt) < (TW'(hl) + TW'(ls));
        o_sts.idx_last_ls  = (r_idx + CW'(1)) == CW'(ls);
        o_sts.len_gt_lim   = r_plen > {26'd0, limit};
        o_sts.cnt_lt_total = TW'(r_cnt) < total;
        o_sts.chk_on       = r_csum_chk && (cs != 3'd0);
        o_sts.len_zero     = (r_plen[LW-1:0] == '0);
        o_sts.idx_last_len = (r_idx + CW'(1)) == CW'(r_plen[LW-1:0]);
        o_sts.sum_bad      = r_sum != r_rd_data;
        o_sts.emit_block   = r_pend_valid && out_busy;
        o_sts.pend_valid   = r_pend_valid;
    end

    `LPFP_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(lpfp_pkg::BUF_DEPTH))

endmodule

FILE: hdl/length_prefixed_frame_parser_unit.sv
// Channel  Direction  Handshake                      Payload
// in       input      i_in_valid / o_in_ready        i_in_byte
// out      output     o_out_valid / i_out_ready      o_status, o_frame_length, o_last
// cfg      input      i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// A word is taken only when the scan controller is idle; each scan step makes one decision, and
// every buffer byte is read through the single read port into a register before it is used.
// A word that leaves too few bytes to start the header or length check ends the scan with a
// flush, and each error restarts the scan.
// Reset is synchronous and clears the buffer pointer and count, the configuration, the scan
// state and the pending and output valid flags.
// A stalled output holds the scan only when a second result is ready to be handed over.
module length_prefixed_frame_parser_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_in_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [lpfp_pkg::LEN_W-1:0] o_frame_length,
    output logic                       o_last,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [31:0]                i_cfg_data
);

    lpfp_pkg::t_cmd cmd;
    lpfp_pkg::t_sts sts;

    lpfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lpfp_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_byte      (i_in_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_frame_length (o_frame_length),
        .o_last         (o_last),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule
